/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ipdfd_pkg.sv */
`default_nettype none
package ipdfd_pkg;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_ARM  = 2'd2;

  localparam logic [2:0] ST_HEADER      = 3'd0;
  localparam logic [2:0] ST_PAYLOAD     = 3'd1;
  localparam logic [2:0] ST_BAD_ID      = 3'd2;
  localparam logic [2:0] ST_BAD_LEN     = 3'd3;
  localparam logic [2:0] ST_HDR_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_PAY_TIMEOUT = 3'd5;

  localparam logic [1:0] CFG_HDR_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_PAY_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_BUF_SIZE    = 2'd2;

  localparam logic [15:0] HDR_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] PAY_TIMEOUT_RST = 16'd3000;
  localparam logic [14:0] BUF_SIZE_RST    = 15'd1024;

  localparam logic [13:0] VALUE_MAX = 14'd16383;
  localparam logic [13:0] ID_MAX    = 14'd4;
  localparam logic [2:0]  MARKER_LEN = 3'd5;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HUNT    = 5'b00010,
    PH_FIELD1  = 5'b00100,
    PH_FIELD2  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] header_timeout_ms;
    logic [15:0] payload_timeout_ms;
    logic [14:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [2:0]  link_id;
    logic        id_present;
    logic [13:0] total_length;
    logic        last;
  } res_t;

  // "+IPD,"
  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h49;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* rtl/ipdfd_in_stage.sv */
`default_nettype none
module ipdfd_in_stage import ipdfd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          stage_valid,
  output in_item_t      stage_item
);

  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipdfd_parser.sv */
`default_nettype none
module ipdfd_parser import ipdfd_pkg::*; #(
  parameter int FIELD_DIGITS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output logic          res_valid,
  output res_t          res
);

  localparam int CW = $clog2(FIELD_DIGITS + 1);

  phase_t          phase, phase_next;
  logic [2:0]      marker_pos, marker_pos_next;
  logic [13:0]     field_value, field_value_next;
  logic [CW-1:0]   field_chars, field_chars_next;
  logic            field_negative, field_negative_next;
  logic            field_stopped, field_stopped_next;
  logic [2:0]      saved_id, saved_id_next;
  logic            have_id, have_id_next;
  logic            id_bad, id_bad_next;
  logic [13:0]     announced_len, announced_len_next;
  logic [13:0]     bytes_left, bytes_left_next;
  logic [15:0]     tick_count, tick_count_next;

  logic [7:0]      c;
  logic            is_digit;
  logic [17:0]     prod;
  logic [13:0]     fv_char;
  logic [CW-1:0]   fc_char;
  logic            fn_char, fs_char;
  logic            id_bad_now;
  logic [13:0]     hdr_left;
  logic [15:0]     tick_inc;
  logic [13:0]     pay_left;
  logic            do_char, do_end;

  assign c        = item.rx_byte;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign prod     = 18'(field_value) * 18'd10 + {14'd0, c[3:0]};

  // one character of a decimal field
  always_comb begin
    fv_char = field_value;
    fc_char = field_chars;
    fn_char = field_negative;
    fs_char = field_stopped;
    if (field_chars < CW'(FIELD_DIGITS)) begin
      priority if (field_chars == '0 && c == CH_MINUS) begin
        fn_char = 1'b1;
      end else if (!field_stopped && is_digit) begin
        fv_char = (prod > 18'(VALUE_MAX)) ? VALUE_MAX : prod[13:0];
      end else begin
        fs_char = 1'b1;
      end
      fc_char = field_chars + CW'(1);
    end
  end

  assign id_bad_now = (field_negative && field_value != '0) || (field_value > ID_MAX);
  assign hdr_left   = ({1'b0, field_value} < cfg.max_payload) ? field_value
                                                              : cfg.max_payload[13:0];
  assign tick_inc   = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  assign pay_left   = (bytes_left != '0) ? bytes_left - 14'd1 : bytes_left;

  always_comb begin
    phase_next          = phase;
    marker_pos_next     = marker_pos;
    field_value_next    = field_value;
    field_chars_next    = field_chars;
    field_negative_next = field_negative;
    field_stopped_next  = field_stopped;
    saved_id_next       = saved_id;
    have_id_next        = have_id;
    id_bad_next         = id_bad;
    announced_len_next  = announced_len;
    bytes_left_next     = bytes_left;
    tick_count_next     = tick_count;
    res_valid           = 1'b0;
    res                 = '0;
    do_char             = 1'b0;
    do_end              = 1'b0;

    if (fire) begin
      unique case (item.action)
        ACT_BYTE: begin
          unique case (phase)
            PH_HUNT: begin
              if (c == marker_char(marker_pos)) begin
                marker_pos_next = marker_pos + 3'd1;
                if (marker_pos + 3'd1 == MARKER_LEN) begin
                  field_value_next    = '0;
                  field_chars_next    = '0;
                  field_negative_next = 1'b0;
                  field_stopped_next  = 1'b0;
                  phase_next          = PH_FIELD1;
                end
              end else begin
                marker_pos_next = (c == CH_PLUS) ? 3'd1 : 3'd0;
              end
            end
            PH_FIELD1: begin
              priority if (c == CH_COMMA) begin
                have_id_next        = 1'b1;
                id_bad_next         = id_bad_now;
                saved_id_next       = id_bad_now ? 3'd0 : field_value[2:0];
                field_value_next    = '0;
                field_chars_next    = '0;
                field_negative_next = 1'b0;
                field_stopped_next  = 1'b0;
                phase_next          = PH_FIELD2;
              end else if (c == CH_COLON) begin
                do_end = 1'b1;
              end else begin
                do_char = 1'b1;
              end
            end
            PH_FIELD2: begin
              if (c == CH_COLON) begin
                do_end = 1'b1;
              end else begin
                do_char = 1'b1;
              end
            end
            PH_PAYLOAD: begin
              bytes_left_next  = pay_left;
              if (pay_left == '0) begin
                phase_next = PH_IDLE;
              end
              res_valid        = 1'b1;
              res.status       = ST_PAYLOAD;
              res.data_byte    = c;
              res.link_id      = saved_id;
              res.id_present   = have_id;
              res.total_length = announced_len;
              res.last         = (pay_left == '0);
            end
            default: begin
            end
          endcase
        end
        ACT_TICK: begin
          if (phase != PH_IDLE) begin
            tick_count_next = tick_inc;
            if (phase == PH_PAYLOAD) begin
              if (tick_inc >= cfg.payload_timeout_ms) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res.status = ST_PAY_TIMEOUT;
                res.last   = 1'b1;
              end
            end else if (tick_inc >= cfg.header_timeout_ms) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.status = ST_HDR_TIMEOUT;
              res.last   = 1'b1;
            end
          end
        end
        ACT_ARM: begin
          phase_next          = PH_HUNT;
          marker_pos_next     = '0;
          field_value_next    = '0;
          field_chars_next    = '0;
          field_negative_next = 1'b0;
          field_stopped_next  = 1'b0;
          saved_id_next       = '0;
          have_id_next        = 1'b0;
          id_bad_next         = 1'b0;
          announced_len_next  = '0;
          bytes_left_next     = '0;
          tick_count_next     = '0;
        end
        default: begin
        end
      endcase

      if (do_char) begin
        field_value_next    = fv_char;
        field_chars_next    = fc_char;
        field_negative_next = fn_char;
        field_stopped_next  = fs_char;
      end

      // header complete at ':'
      if (do_end) begin
        res_valid = 1'b1;
        priority if (have_id && id_bad) begin
          phase_next = PH_IDLE;
          res.status = ST_BAD_ID;
          res.last   = 1'b1;
        end else if (field_value == '0 || field_negative) begin
          phase_next = PH_IDLE;
          res.status = ST_BAD_LEN;
          res.last   = 1'b1;
        end else begin
          announced_len_next = field_value;
          bytes_left_next    = hdr_left;
          tick_count_next    = '0;
          phase_next         = (hdr_left == '0) ? PH_IDLE : PH_PAYLOAD;
          res.status         = ST_HEADER;
          res.link_id        = saved_id;
          res.id_present     = have_id;
          res.total_length   = field_value;
          res.last           = (hdr_left == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      marker_pos     <= '0;
      field_value    <= '0;
      field_chars    <= '0;
      field_negative <= 1'b0;
      field_stopped  <= 1'b0;
      saved_id       <= '0;
      have_id        <= 1'b0;
      id_bad         <= 1'b0;
      announced_len  <= '0;
      bytes_left     <= '0;
      tick_count     <= '0;
    end else begin
      phase          <= phase_next;
      marker_pos     <= marker_pos_next;
      field_value    <= field_value_next;
      field_chars    <= field_chars_next;
      field_negative <= field_negative_next;
      field_stopped  <= field_stopped_next;
      saved_id       <= saved_id_next;
      have_id        <= have_id_next;
      id_bad         <= id_bad_next;
      announced_len  <= announced_len_next;
      bytes_left     <= bytes_left_next;
      tick_count     <= tick_count_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipdfd_out_reg.sv */
`default_nettype none
module ipdfd_out_reg import ipdfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t load_res,
  input  wire logic out_ready,
  output logic      out_valid,
  output res_t      out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipd_frame_deframer_core.sv */
// path: input register first, then the parsed result into the result register
// throughput: one request per cycle unless stalled, set by input and result register
// handshake; a held result only stalls the input once the input register is full
// reset (rst, synchronous, active high): disarmed, no result pending, timeouts
// back to 1000 and 3000 ticks, buffer size back to 1024
`default_nettype none
module ipd_frame_deframer_core import ipdfd_pkg::*; #(
  parameter int FIELD_DIGITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  input  wire logic [1:0]  s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // data_byte, link_id, id_present, total_length
  output logic [2:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  `include "assert_macros.svh"

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     take;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_timeout_ms  <= HDR_TIMEOUT_RST;
      cfg.payload_timeout_ms <= PAY_TIMEOUT_RST;
      cfg.max_payload        <= BUF_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HDR_TIMEOUT: cfg.header_timeout_ms  <= cfg_data;
        CFG_PAY_TIMEOUT: cfg.payload_timeout_ms <= cfg_data;
        CFG_BUF_SIZE:    cfg.max_payload        <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.action  = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  assign take = stage_valid && (!m_axis_tvalid || m_axis_tready);

  ipdfd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  ipdfd_parser #(
    .FIELD_DIGITS (FIELD_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (take),
    .item      (stage_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ipdfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.total_length, out_res.id_present,
                         out_res.link_id, out_res.data_byte};
  assign m_axis_tuser = out_res.status;
  assign m_axis_tlast = out_res.last;

  `ASSERT_CLK_ALWAYS(a_reset_clears_out, rst |=> !m_axis_tvalid, "result valid after reset")
  `ASSERT_CLK(a_error_is_last, (m_axis_tvalid && m_axis_tuser >= ST_BAD_ID) |-> m_axis_tlast,
    "error result without last")
  `ASSERT_CLK(a_error_no_payload,
    (m_axis_tvalid && m_axis_tuser >= ST_BAD_ID) |-> (m_axis_tdata == '0),
    "error result carries header or data fields")
  `ASSERT_CLK(a_stall_only_when_full, !s_axis_tready |-> stage_valid,
    "input stalled with empty input register")

endmodule
`default_nettype wire
